// ===== design/sose_pkg.sv =====
// Shared types and constants for the small set operation engine.
package sose_pkg;

    localparam int SOSE_CAPACITY = 16;
    localparam int ELEM_W        = 32;

    typedef enum logic [1:0] {
        OP_CLEAR    = 2'd0,
        OP_APPEND_A = 2'd1,
        OP_APPEND_B = 2'd2,
        OP_QUERY    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        QK_INTERSECT = 2'd0,
        QK_A_MINUS_B = 2'd1,
        QK_B_MINUS_A = 2'd2,
        QK_UNION     = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PHASE,
        ST_OFETCH,
        ST_OLOAD,
        ST_SCAN,
        ST_PUSH,
        ST_FLUSH
    } t_seq_state;

    typedef struct packed {
        logic              vld;
        t_op               op;
        logic [ELEM_W-1:0] elem;
    } t_wr_cmd;

endpackage

// ===== design/sose_store.sv =====
// Element memories for sets A and B with fill counts and the sticky overflow flag.
module sose_store
    import sose_pkg::*;
#(
    parameter int SET_CAPACITY = SOSE_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_wr_cmd              i_wr,
    input  logic [(SET_CAPACITY > 1 ? $clog2(SET_CAPACITY) : 1)-1:0] i_a_addr,
    input  logic [(SET_CAPACITY > 1 ? $clog2(SET_CAPACITY) : 1)-1:0] i_b_addr,
    output logic [ELEM_W-1:0]    o_a_rdata,
    output logic [ELEM_W-1:0]    o_b_rdata,
    output logic [$clog2(SET_CAPACITY+1)-1:0] o_cnt_a,
    output logic [$clog2(SET_CAPACITY+1)-1:0] o_cnt_b,
    output logic                 o_ovf
);

    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    logic [ELEM_W-1:0] mem_a [SET_CAPACITY];
    logic [ELEM_W-1:0] mem_b [SET_CAPACITY];

    logic [CW-1:0] r_cnt_a, r_cnt_b;
    logic          r_ovf;
    logic [ELEM_W-1:0] r_a_rdata, r_b_rdata;

    logic a_room, b_room;
    assign a_room = (r_cnt_a < CW'(SET_CAPACITY));
    assign b_room = (r_cnt_b < CW'(SET_CAPACITY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_a <= '0;
            r_cnt_b <= '0;
            r_ovf   <= 1'b0;
        end else if (i_wr.vld) begin
            unique case (i_wr.op)
                OP_CLEAR: begin
                    r_cnt_a <= '0;
                    r_cnt_b <= '0;
                    r_ovf   <= 1'b0;
                end
                OP_APPEND_A: begin
                    if (a_room) r_cnt_a <= r_cnt_a + CW'(1);
                    else        r_ovf   <= 1'b1;
                end
                OP_APPEND_B: begin
                    if (b_room) r_cnt_b <= r_cnt_b + CW'(1);
                    else        r_ovf   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Memory write ports: append lands at the current fill count.
    always_ff @(posedge i_clk) begin
        if (i_wr.vld && i_wr.op == OP_APPEND_A && a_room) begin
            mem_a[r_cnt_a[IW-1:0]] <= i_wr.elem;
        end
        if (i_wr.vld && i_wr.op == OP_APPEND_B && b_room) begin
            mem_b[r_cnt_b[IW-1:0]] <= i_wr.elem;
        end
    end

    // Registered read ports.
    always_ff @(posedge i_clk) begin
        r_a_rdata <= mem_a[i_a_addr];
        r_b_rdata <= mem_b[i_b_addr];
    end

    assign o_a_rdata = r_a_rdata;
    assign o_b_rdata = r_b_rdata;
    assign o_cnt_a   = r_cnt_a;
    assign o_cnt_b   = r_cnt_b;
    assign o_ovf     = r_ovf;

endmodule

// ===== design/sose_seq.sv =====
// Query sequencer: outer/inner scan over the set memories and the result output register.
module sose_seq
    import sose_pkg::*;
#(
    parameter int SET_CAPACITY = SOSE_CAPACITY
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  t_kind                i_kind,
    input  logic [$clog2(SET_CAPACITY+1)-1:0] i_cnt_a,
    input  logic [$clog2(SET_CAPACITY+1)-1:0] i_cnt_b,
    input  logic                 i_ovf,
    output logic                 o_idle,
    output logic [(SET_CAPACITY > 1 ? $clog2(SET_CAPACITY) : 1)-1:0] o_a_addr,
    output logic [(SET_CAPACITY > 1 ? $clog2(SET_CAPACITY) : 1)-1:0] o_b_addr,
    input  logic [ELEM_W-1:0]    i_a_rdata,
    input  logic [ELEM_W-1:0]    i_b_rdata,
    output logic                 o_out_vld,
    input  logic                 i_out_rdy,
    output logic [ELEM_W-1:0]    o_out_val,
    output logic                 o_out_vres,
    output logic                 o_out_last,
    output logic                 o_out_ovf
);

    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    t_seq_state        r_state, n_state;
    t_kind             r_kind, n_kind;
    logic              r_phase, n_phase;
    logic              r_ovf, n_ovf;
    logic [CW-1:0]     r_ca, n_ca, r_cb, n_cb;
    logic [CW-1:0]     r_i, n_i, r_left, n_left, r_k, n_k, r_cidx, n_cidx;
    logic              r_seg, n_seg, r_cseg, n_cseg, r_cvld, n_cvld;
    logic              r_resume, n_resume;
    logic [ELEM_W-1:0] r_outer, n_outer, r_pend, n_pend;
    logic              r_pend_vld, n_pend_vld;
    logic              r_out_vld, n_out_vld, r_out_vres, n_out_vres, r_out_last, n_out_last;
    logic              r_out_ovf, n_out_ovf;
    logic [ELEM_W-1:0] r_out_val, n_out_val;

    logic              out_free, up, outer_b, inner_a, match, iss0, iss1;
    logic [CW-1:0]     outer_cnt, inner_cnt, next_i;
    logic [ELEM_W-1:0] outer_rd, cmp_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_cvld     <= 1'b0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cvld     <= n_cvld;
            r_pend_vld <= n_pend_vld;
            r_out_vld  <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_phase    <= n_phase;
        r_ovf      <= n_ovf;
        r_ca       <= n_ca;
        r_cb       <= n_cb;
        r_i        <= n_i;
        r_left     <= n_left;
        r_k        <= n_k;
        r_cidx     <= n_cidx;
        r_seg      <= n_seg;
        r_cseg     <= n_cseg;
        r_resume   <= n_resume;
        r_outer    <= n_outer;
        r_pend     <= n_pend;
        r_out_val  <= n_out_val;
        r_out_vres <= n_out_vres;
        r_out_last <= n_out_last;
        r_out_ovf  <= n_out_ovf;
    end

    // Outer walk: forward over A for intersection, forward over B for the
    // union's first pass, reverse otherwise.
    assign up        = (r_kind == QK_INTERSECT) || (r_kind == QK_UNION && !r_phase);
    assign outer_b   = (r_kind == QK_B_MINUS_A) || (r_kind == QK_UNION && !r_phase);
    assign inner_a   = (r_kind == QK_B_MINUS_A) || (r_kind == QK_UNION);
    assign outer_cnt = outer_b ? r_cb : r_ca;
    assign inner_cnt = inner_a ? r_ca : r_cb;
    assign outer_rd  = outer_b ? i_b_rdata : i_a_rdata;
    // Segment 0 scans later entries of B (union duplicate check).
    assign cmp_rd    = (!r_cseg || !inner_a) ? i_b_rdata : i_a_rdata;
    assign match     = r_cvld && (cmp_rd == r_outer);
    assign iss0      = !r_seg && (r_k < r_cb);
    assign iss1      = r_seg && (r_k < inner_cnt);
    assign next_i    = up ? r_i + CW'(1) : r_i - CW'(1);
    assign out_free  = !r_out_vld || i_out_rdy;

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_phase    = r_phase;
        n_ovf      = r_ovf;
        n_ca       = r_ca;
        n_cb       = r_cb;
        n_i        = r_i;
        n_left     = r_left;
        n_k        = r_k;
        n_cidx     = r_cidx;
        n_seg      = r_seg;
        n_cseg     = r_cseg;
        n_cvld     = r_cvld;
        n_resume   = r_resume;
        n_outer    = r_outer;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        n_out_vld  = r_out_vld && !i_out_rdy;
        n_out_val  = r_out_val;
        n_out_vres = r_out_vres;
        n_out_last = r_out_last;
        n_out_ovf  = r_out_ovf;
        o_a_addr   = '0;
        o_b_addr   = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_kind     = i_kind;
                    n_phase    = 1'b0;
                    n_ovf      = i_ovf;
                    n_ca       = i_cnt_a;
                    n_cb       = i_cnt_b;
                    n_pend_vld = 1'b0;
                    n_state    = ST_PHASE;
                end
            end
            ST_PHASE: begin
                n_left  = outer_cnt;
                n_i     = up ? '0 : outer_cnt - CW'(1);
                n_state = ST_OFETCH;
            end
            ST_OFETCH: begin
                if (r_left == '0) begin
                    if (r_kind == QK_UNION && !r_phase) begin
                        n_phase = 1'b1;
                        n_state = ST_PHASE;
                    end else begin
                        n_state = ST_FLUSH;
                    end
                end else begin
                    if (outer_b) o_b_addr = r_i[IW-1:0];
                    else         o_a_addr = r_i[IW-1:0];
                    n_state = ST_OLOAD;
                end
            end
            ST_OLOAD: begin
                n_outer = outer_rd;
                n_cvld  = 1'b0;
                if (r_kind == QK_UNION && r_phase) begin
                    // Union second pass: every A entry goes out unchecked.
                    n_resume = 1'b0;
                    n_state  = ST_PUSH;
                end else begin
                    n_seg   = (r_kind != QK_UNION);
                    n_k     = (r_kind == QK_UNION) ? r_i + CW'(1) : '0;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (iss0) begin
                    o_b_addr = r_k[IW-1:0];
                    n_cvld   = 1'b1;
                    n_cseg   = 1'b0;
                    n_cidx   = r_k;
                    n_k      = r_k + CW'(1);
                end else if (!r_seg) begin
                    n_seg  = 1'b1;
                    n_k    = '0;
                    n_cvld = 1'b0;
                end else if (iss1) begin
                    if (inner_a) o_a_addr = r_k[IW-1:0];
                    else         o_b_addr = r_k[IW-1:0];
                    n_cvld = 1'b1;
                    n_cseg = 1'b1;
                    n_cidx = r_k;
                    n_k    = r_k + CW'(1);
                end else begin
                    n_cvld = 1'b0;
                end

                if (match) begin
                    n_cvld = 1'b0;
                    if (r_kind == QK_INTERSECT) begin
                        // Emit, then resume the scan after the matching entry.
                        n_k      = r_cidx + CW'(1);
                        n_seg    = 1'b1;
                        n_resume = 1'b1;
                        n_state  = ST_PUSH;
                    end else begin
                        n_left  = r_left - CW'(1);
                        n_i     = next_i;
                        n_state = ST_OFETCH;
                    end
                end else if (!r_cvld && r_seg && !iss1) begin
                    if (r_kind == QK_INTERSECT) begin
                        n_left  = r_left - CW'(1);
                        n_i     = next_i;
                        n_state = ST_OFETCH;
                    end else begin
                        n_resume = 1'b0;
                        n_state  = ST_PUSH;
                    end
                end
            end
            ST_PUSH: begin
                // Hold one item back so the final one can carry last.
                if (!r_pend_vld || out_free) begin
                    if (r_pend_vld) begin
                        n_out_vld  = 1'b1;
                        n_out_val  = r_pend;
                        n_out_vres = 1'b1;
                        n_out_last = 1'b0;
                        n_out_ovf  = r_ovf;
                    end
                    n_pend     = r_outer;
                    n_pend_vld = 1'b1;
                    if (r_resume) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_left  = r_left - CW'(1);
                        n_i     = next_i;
                        n_state = ST_OFETCH;
                    end
                end
            end
            ST_FLUSH: begin
                if (out_free) begin
                    n_out_vld  = 1'b1;
                    n_out_val  = r_pend_vld ? r_pend : '0;
                    n_out_vres = r_pend_vld;
                    n_out_last = 1'b1;
                    n_out_ovf  = r_ovf;
                    n_pend_vld = 1'b0;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_idle     = (r_state == ST_IDLE);
    assign o_out_vld  = r_out_vld;
    assign o_out_val  = r_out_val;
    assign o_out_vres = r_out_vres;
    assign o_out_last = r_out_last;
    assign o_out_ovf  = r_out_ovf;

endmodule

// ===== design/small_set_operation_engine_unit.sv =====
// Top level of the small set operation engine: stream ports, set store and query sequencer.
//
// Holds two sets A and B of up to SET_CAPACITY 32-bit elements in two synchronous
// memories with one write and one read port each. Clear and append transfers update
// the store directly; appends to a full set are dropped and set the sticky overflow
// flag, reported on every result item. A query streams its result on the master side,
// ending with tlast; an empty result is one item with valid_res low. Each memory has
// one read port, so a query visits the outer set one element at a time: it fetches the
// element, compares it with the inner entries one by one, stopping at the first match
// for the differences and the union, and then pushes an element that found no match.
// The intersection instead pushes each match and resumes the scan after it. The union
// first checks each B element against the later B entries and then against A, and
// afterwards pushes every A element unchecked. No transfer is taken while a query runs;
// a finished item waits in the output register without holding up the next transfer.
module small_set_operation_engine_unit
    import sose_pkg::*;
#(
    parameter int SET_CAPACITY = SOSE_CAPACITY
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [39:0] i_s_tdata,   // [31:0] element, [33:32] query_kind, rest zero
    input  logic [1:0]  i_s_tuser,   // [1:0] op
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] value
    output logic [1:0]  o_m_tuser,   // [0] valid_res, [1] overflow
    output logic        o_m_tlast
);

    localparam int CW = $clog2(SET_CAPACITY + 1);
    localparam int IW = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;

    logic              in_xfer, seq_idle, ovf;
    t_op               in_op;
    t_wr_cmd           wr_cmd;
    logic [IW-1:0]     a_addr, b_addr;
    logic [ELEM_W-1:0] a_rdata, b_rdata;
    logic [CW-1:0]     cnt_a, cnt_b;
    logic              out_vres, out_ovf;

    assign in_op   = t_op'(i_s_tuser[1:0]);
    assign in_xfer = i_s_tvalid && o_s_tready;

    assign wr_cmd.vld  = in_xfer && (in_op != OP_QUERY);
    assign wr_cmd.op   = in_op;
    assign wr_cmd.elem = i_s_tdata[ELEM_W-1:0];

    sose_store #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (wr_cmd),
        .i_a_addr  (a_addr),
        .i_b_addr  (b_addr),
        .o_a_rdata (a_rdata),
        .o_b_rdata (b_rdata),
        .o_cnt_a   (cnt_a),
        .o_cnt_b   (cnt_b),
        .o_ovf     (ovf)
    );

    sose_seq #(
        .SET_CAPACITY (SET_CAPACITY)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (in_xfer && (in_op == OP_QUERY)),
        .i_kind     (t_kind'(i_s_tdata[33:32])),
        .i_cnt_a    (cnt_a),
        .i_cnt_b    (cnt_b),
        .i_ovf      (ovf),
        .o_idle     (seq_idle),
        .o_a_addr   (a_addr),
        .o_b_addr   (b_addr),
        .i_a_rdata  (a_rdata),
        .i_b_rdata  (b_rdata),
        .o_out_vld  (o_m_tvalid),
        .i_out_rdy  (i_m_tready),
        .o_out_val  (o_m_tdata),
        .o_out_vres (out_vres),
        .o_out_last (o_m_tlast),
        .o_out_ovf  (out_ovf)
    );

    assign o_s_tready = seq_idle;
    assign o_m_tuser  = {out_ovf, out_vres};

    // Set contents must not move under a running query.
    a_store_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |=> ($stable(cnt_a) && $stable(cnt_b) && $stable(ovf)))
        else $error("set store changed during a query");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cnt_a <= CW'(SET_CAPACITY)) && (cnt_b <= CW'(SET_CAPACITY)))
        else $error("fill count beyond capacity");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && in_op == OP_CLEAR) |=> (cnt_a == '0 && cnt_b == '0 && !ovf))
        else $error("clear did not empty both sets");

endmodule
